// File: rtl/waypoint_path_interpolator_assert.svh
// assertion macros for the waypoint path interpolator
`ifndef WAYPOINT_PATH_INTERPOLATOR_ASSERT_SVH
`define WAYPOINT_PATH_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTH
`define WPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WPI_ASSERT_IMP(lbl, ante, cons)
`define WPI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/wpi_pkg.sv
package wpi_pkg;

  localparam int MAX_SEGMENTS = 4096;
  localparam int NW = 13;
  localparam int NNW = 25;
  localparam int DW = 33;
  localparam int QW = 34;
  localparam int RW = 60;
  localparam int CORDIC_STEPS = 17;
  localparam int CW = 36;
  localparam int ZW = 20;
  localparam int HALF_PI_Q16 = 102944;
  localparam int HEADING_MAX = 25736;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_LON   = 3'd0,
    REG_START_LAT   = 3'd1,
    REG_START_DEPTH = 3'd2,
    REG_END_LON     = 3'd3,
    REG_END_LAT     = 3'd4,
    REG_END_DEPTH   = 3'd5,
    REG_SEG_COUNT   = 3'd6,
    REG_DEPTH_PROF  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HD_IDLE,
    HD_RUN,
    HD_ROUND
  } hd_state_t;

  // one word in flight through the divider stages, lanes lon, lat, depth
  typedef struct packed {
    logic                  err;
    logic                  last;
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][RW-1:0]    rem;
    logic [2:0][QW-1:0]    q;
  } div_t;

  // arctangent table, Q16.16 radians
  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] k);
    logic [ZW-1:0] v;
    unique case (k)
      5'd0:    v = ZW'(51472);
      5'd1:    v = ZW'(30386);
      5'd2:    v = ZW'(16055);
      5'd3:    v = ZW'(8150);
      5'd4:    v = ZW'(4091);
      5'd5:    v = ZW'(2047);
      5'd6:    v = ZW'(1024);
      5'd7:    v = ZW'(512);
      5'd8:    v = ZW'(256);
      5'd9:    v = ZW'(128);
      5'd10:   v = ZW'(64);
      5'd11:   v = ZW'(32);
      5'd12:   v = ZW'(16);
      5'd13:   v = ZW'(8);
      5'd14:   v = ZW'(4);
      5'd15:   v = ZW'(2);
      5'd16:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/waypoint_path_interpolator.sv
// throughput: one word per cycle while in_stall is low; the pipeline of
// products and a 34-stage restoring divider holds up to 38 words at once
// reset and every configuration write start a setup (deltas and
// the CORDIC heading, one step a cycle) during which in_stall is high
module waypoint_path_interpolator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [12:0]         in_point_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_lon_out,
  output logic signed [30:0]  out_lat_out,
  output logic signed [31:0]  out_depth_out,
  output logic signed [15:0]  out_heading,
  output logic                out_is_last,
  output logic                out_index_error
);
  import wpi_pkg::*;

  localparam int NDIV = QW + 1;
  localparam int NST  = NDIV + 3;

  // configuration registers
  logic signed [31:0] start_lon_r, start_depth_r, end_lon_r, end_depth_r;
  logic signed [30:0] start_lat_r, end_lat_r;
  logic [NW-1:0] seg_r;
  logic prof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_lon_r   <= '0;
      start_lat_r   <= '0;
      start_depth_r <= '0;
      end_lon_r     <= '0;
      end_lat_r     <= '0;
      end_depth_r   <= '0;
      seg_r         <= NW'(1);
      prof_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_LON:   start_lon_r   <= cfg_wdata;
        REG_START_LAT:   start_lat_r   <= cfg_wdata[30:0];
        REG_START_DEPTH: start_depth_r <= cfg_wdata;
        REG_END_LON:     end_lon_r     <= cfg_wdata;
        REG_END_LAT:     end_lat_r     <= cfg_wdata[30:0];
        REG_END_DEPTH:   end_depth_r   <= cfg_wdata;
        REG_SEG_COUNT:   seg_r         <= cfg_wdata[NW-1:0];
        REG_DEPTH_PROF:  prof_r        <= cfg_wdata[0];
        default:         prof_r        <= prof_r;
      endcase
    end
  end

  // setup: deltas, clamped count and its square
  logic prep_r, hd_start_r;
  logic signed [DW-1:0] dlon_r, dlat_r, ddep_r;
  logic [NW-1:0] n_r;
  logic [NNW-1:0] nn_r;
  logic [NW-1:0] n_clamp;
  logic hd_busy, busy;
  logic signed [15:0] hd;

  assign n_clamp = (seg_r > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : seg_r;

  // heading starts in the cycle after the deltas settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r     <= 1'b1;
      hd_start_r <= 1'b0;
    end else begin
      prep_r     <= cfg_we;
      hd_start_r <= prep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_r) begin
      dlon_r <= DW'(end_lon_r) - DW'(start_lon_r);
      dlat_r <= DW'(end_lat_r) - DW'(start_lat_r);
      ddep_r <= DW'(end_depth_r) - DW'(start_depth_r);
      n_r    <= n_clamp;
      nn_r   <= NNW'(n_clamp) * NNW'(n_clamp);
    end
  end

  wpi_heading u_heading (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hd_start_r),
    .dlon    (dlon_r),
    .dlat    (dlat_r),
    .busy    (hd_busy),
    .heading (hd)
  );

  assign busy = prep_r | hd_start_r | cfg_we | hd_busy;

  // valid and ready chain
  logic [NST-1:0] v_r;
  logic [NST:0] rdy;
  logic acc;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = busy || !rdy[0];
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= acc;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: index, flags, i squared
  logic [NW-1:0] i0_r;
  logic [NNW-1:0] ii0_r;
  logic err0_r, last0_r, zero0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      i0_r    <= in_point_index;
      ii0_r   <= NNW'(in_point_index) * NNW'(in_point_index);
      err0_r  <= in_point_index > n_r;
      last0_r <= in_point_index == n_r;
      zero0_r <= (in_point_index == '0) || (n_r == '0);
    end
  end

  // stage 1: products
  logic signed [RW-1:0] p1_r [3];
  logic err1_r, last1_r, zero1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1_r[0] <= RW'(dlon_r) * RW'($signed({1'b0, i0_r}));
      p1_r[1] <= RW'(dlat_r) * RW'($signed({1'b0, i0_r}));
      p1_r[2] <= RW'(ddep_r) * RW'($signed({1'b0, ii0_r}));
      err1_r  <= err0_r;
      last1_r <= last0_r;
      zero1_r <= zero0_r;
    end
  end

  // stage 2: rounded numerator 2|p| + den, then divider stages
  div_t dv_r [NDIV];
  div_t dv_nxt [NDIV];
  logic [RW-1:0] den2 [3];
  logic [RW-1:0] mag;

  assign den2[0] = RW'({n_r, 1'b0});
  assign den2[1] = RW'({n_r, 1'b0});
  assign den2[2] = RW'({nn_r, 1'b0});

  always_comb begin
    dv_nxt[0]      = '0;
    dv_nxt[0].err  = err1_r;
    dv_nxt[0].last = last1_r;
    dv_nxt[0].zero = zero1_r;
    for (int l = 0; l < 3; l++) begin
      mag = p1_r[l][RW-1] ? RW'(-p1_r[l]) : RW'(p1_r[l]);
      dv_nxt[0].neg[l] = p1_r[l][RW-1];
      dv_nxt[0].rem[l] = (mag << 1) + (den2[l] >> 1);
    end
    // one quotient bit per stage, most significant first
    for (int j = 1; j < NDIV; j++) begin
      dv_nxt[j] = dv_r[j-1];
      for (int l = 0; l < 3; l++) begin
        if (dv_r[j-1].rem[l] >= (den2[l] << (QW - j))) begin
          dv_nxt[j].rem[l] = dv_r[j-1].rem[l] - (den2[l] << (QW - j));
          dv_nxt[j].q[l][QW-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIV; j++) begin
      if (rdy[j+2]) dv_r[j] <= dv_nxt[j];
    end
  end

  // output stage: add signed offsets to start values
  logic signed [QW:0] off [3];
  logic signed [31:0] lon_nxt, dep_nxt;
  logic signed [30:0] lat_nxt;
  logic signed [15:0] hd_nxt;
  logic signed [31:0] lon_r, dep_r;
  logic signed [30:0] lat_r;
  logic signed [15:0] hd_r;
  logic last_r, err_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      off[l] = dv_r[NDIV-1].neg[l] ? -$signed({1'b0, dv_r[NDIV-1].q[l]})
                                    : $signed({1'b0, dv_r[NDIV-1].q[l]});
    end
    lon_nxt = start_lon_r;
    lat_nxt = start_lat_r;
    dep_nxt = start_depth_r;
    if (!dv_r[NDIV-1].zero) begin
      lon_nxt = start_lon_r + off[0][31:0];
      lat_nxt = start_lat_r + off[1][30:0];
      if (!prof_r) dep_nxt = start_depth_r + off[2][31:0];
    end
    hd_nxt = dv_r[NDIV-1].last ? '0 : hd;
    if (dv_r[NDIV-1].err) begin
      lon_nxt = '0;
      lat_nxt = '0;
      dep_nxt = '0;
      hd_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      lon_r  <= lon_nxt;
      lat_r  <= lat_nxt;
      dep_r  <= dep_nxt;
      hd_r   <= hd_nxt;
      last_r <= dv_r[NDIV-1].last && !dv_r[NDIV-1].err;
      err_r  <= dv_r[NDIV-1].err;
    end
  end

  assign out_valid       = v_r[NST-1];
  assign out_lon_out     = lon_r;
  assign out_lat_out     = lat_r;
  assign out_depth_out   = dep_r;
  assign out_heading     = hd_r;
  assign out_is_last     = last_r;
  assign out_index_error = err_r;

`include "waypoint_path_interpolator_assert.svh"

  `WPI_ASSERT_IMP(a_err_zero, out_valid && out_index_error, out_lon_out == 0 && out_depth_out == 0)
  `WPI_ASSERT_IMP(a_last_no_err, out_valid && out_is_last, !out_index_error && out_heading == 0)
  `WPI_ASSERT_NXT(a_cfg_blocks, cfg_we, in_stall)

endmodule

// File: rtl/wpi_heading.sv
module wpi_heading (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [32:0]   dlon,
  input  logic signed [32:0]   dlat,
  output logic                 busy,
  output logic signed [15:0]   heading
);
  import wpi_pkg::*;

  hd_state_t state_r, state_nxt;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys, x0, y0;
  logic signed [ZW-1:0] z_r, z_nxt, z0;
  logic [4:0] k_r;
  logic zero_r;
  logic signed [15:0] heading_r;
  logic [ZW-1:0] zmag;
  logic [ZW-1:0] m;
  logic signed [15:0] h_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      HD_IDLE:  state_nxt = HD_IDLE;
      HD_RUN:   if (k_r == 5'(CORDIC_STEPS - 1)) state_nxt = HD_ROUND;
      HD_ROUND: state_nxt = HD_IDLE;
      default:  state_nxt = HD_IDLE;
    endcase
    if (start) state_nxt = HD_RUN;
  end

  // quadrant fold of the start vector
  always_comb begin
    x0 = CW'(dlat);
    y0 = CW'(dlon);
    z0 = '0;
    if (dlat < 0) begin
      if (dlon >= 0) begin
        x0 = CW'(dlon);
        y0 = -CW'(dlat);
        z0 = ZW'(HALF_PI_Q16);
      end else begin
        x0 = -CW'(dlon);
        y0 = CW'(dlat);
        z0 = -ZW'(HALF_PI_Q16);
      end
    end
  end

  // one vectoring step
  always_comb begin
    xs = x_r >>> k_r;
    ys = y_r >>> k_r;
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + $signed(atan_q16(k_r));
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - $signed(atan_q16(k_r));
    end
  end

  // round Q16 angle to Q3.13 and clamp
  always_comb begin
    zmag = z_r[ZW-1] ? ZW'(-z_r) : ZW'(z_r);
    m = (zmag + ZW'(4)) >> 3;
    if (m > ZW'(HEADING_MAX)) m = ZW'(HEADING_MAX);
    h_nxt = z_r[ZW-1] ? -$signed(m[15:0]) : $signed(m[15:0]);
    if (zero_r) h_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
    end else if (start) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      k_r    <= '0;
      zero_r <= (dlon == 0) && (dlat == 0);
    end else if (state_r == HD_RUN) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      k_r <= k_r + 5'd1;
    end else if (state_r == HD_ROUND) begin
      heading_r <= h_nxt;
    end
  end

  assign busy    = (state_r != HD_IDLE);
  assign heading = heading_r;

endmodule
